FILE: rtl/core/rcsm_pkg.sv
// shared types, constants and the byte fold function for the crc-32 signature matcher
package rcsm_pkg;

   // crc word and reflected polynomial
   localparam int unsigned CRC_W = 32;
   typedef logic [CRC_W-1:0] crc_type;
   localparam crc_type CRC_POLY = 32'hEDB8_8320;
   localparam crc_type CRC_ONES = 32'hFFFF_FFFF;

   // byte item
   localparam int unsigned BYTE_W = 8;
   typedef logic [BYTE_W-1:0] byte_type;

   // known signature table
   localparam int unsigned SIG_COUNT = 8;
   localparam int unsigned IDX_W     = 3;
   typedef logic [IDX_W-1:0] sig_idx_type;
   localparam crc_type SIG_TABLE [SIG_COUNT] = '{
      32'hA6CE_1636, 32'hC4F0_F55F, 32'hC3BD_B240, 32'h6446_6C2A,
      32'h43B0_DF7B, 32'hFC24_AE0D, 32'h568F_8786, 32'hE1F5_0B0B
   };

   // result item layout: crc, then index, padded to whole bytes
   localparam int unsigned RSP_FIELD_W = CRC_W + IDX_W;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // outcome of the signature compare
   typedef struct packed {
      logic        matched;
      sig_idx_type index;
   } match_type;

   // fold one byte into the running crc, lsb first
   function automatic crc_type fold_byte(input crc_type crc_in, input byte_type data_in);
      crc_type c;
      c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/rcsm_match.sv
// compares a final crc against the known signature table and reports the first hit
module rcsm_match #(
   parameter int unsigned NUM_SIGNATURES = 8
) (
   input  rcsm_pkg::crc_type   crc_value,
   output rcsm_pkg::match_type match
);

   // entries beyond the table never match
   localparam int unsigned NumActive =
      (NUM_SIGNATURES < rcsm_pkg::SIG_COUNT) ? NUM_SIGNATURES : rcsm_pkg::SIG_COUNT;

   // scan from the top down so the lowest matching entry wins
   always_comb begin
      match.matched = 1'b0;
      match.index   = '0;
      for (int i = NumActive - 1; i >= 0; i--) begin
         if (rcsm_pkg::SIG_TABLE[i] == crc_value) begin
            match.matched = 1'b1;
            match.index   = rcsm_pkg::IDX_W'(i);
         end
      end
   end

endmodule

FILE: rtl/core/rom_crc32_signature_match.sv
// top level of the crc-32 signature matcher
//
// The req channel carries an image one byte per item; req_tlast marks the
// final byte. Each byte is folded into a running reflected crc-32 (initial
// value all ones). The final byte of an image yields one item on the rsp
// channel: the crc after output inversion, the index of the first matching
// known signature in rsp_tdata, and a match flag on rsp_tuser. Bytes that are
// not last produce nothing on rsp. After a last byte the running crc goes
// back to all ones for the next image.
//
// Throughput is one byte per cycle, except while a last byte waits for the
// result register: the whole byte fold and the signature compare sit between
// the input and result registers, and loading the result raises rsp_tvalid.
// Reset clears both registers' valid flags and loads the running crc with
// all ones. While rsp is stalled, non-last bytes still fold in; a last byte
// waits in the input register until the result register frees, and req_tready
// stays low for as long as it waits.
module rom_crc32_signature_match #(
   parameter int unsigned NUM_SIGNATURES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rcsm_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [31:0] crc_value, [34:32] match_index
   output logic                                rsp_tuser    // matched
);

   // input register
   logic                s1_valid_ff, s1_valid_in;
   rcsm_pkg::byte_type  s1_byte_ff,  s1_byte_in;
   logic                s1_last_ff,  s1_last_in;

   // running crc
   rcsm_pkg::crc_type   crc_ff, crc_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   rcsm_pkg::crc_type   rsp_crc_ff,   rsp_crc_in;
   rcsm_pkg::match_type rsp_match_ff, rsp_match_in;

   // datapath
   rcsm_pkg::crc_type   crc_folded;
   rcsm_pkg::crc_type   crc_final;
   rcsm_pkg::match_type match_now;
   logic                out_free;
   logic                s1_advance;
   logic                req_take;

   // byte fold and output inversion
   assign crc_folded = rcsm_pkg::fold_byte(crc_ff, s1_byte_ff);
   assign crc_final  = crc_folded ^ rcsm_pkg::CRC_ONES;

   rcsm_match #(
      .NUM_SIGNATURES(NUM_SIGNATURES)
   ) u_match (
      .crc_value(crc_final),
      .match    (match_now)
   );

   // flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   // next values
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      s1_last_in   = s1_last_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_match_in = rsp_match_ff;

      // input register
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      // result register drains
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // fold the held byte; a last byte also loads a result
      if (s1_advance) begin
         if (s1_last_ff) begin
            crc_in       = rcsm_pkg::CRC_ONES;
            rsp_valid_in = 1'b1;
            rsp_crc_in   = crc_final;
            rsp_match_in = match_now;
         end else begin
            crc_in = crc_folded;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= rcsm_pkg::CRC_ONES;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      s1_last_ff   <= s1_last_in;
      rsp_crc_ff   <= rsp_crc_in;
      rsp_match_ff <= rsp_match_in;
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{rcsm_pkg::RSP_PAD_W{1'b0}}, rsp_match_ff.index, rsp_crc_ff};
   assign rsp_tuser  = rsp_match_ff.matched;

endmodule

FILE: rtl/core/rcsm_checker.sv
// port-level checks for the crc-32 signature matcher, bound to the top level
module rcsm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rcsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   // a stalled result item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // no match means index zero
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[rcsm_pkg::RSP_FIELD_W-1:rcsm_pkg::CRC_W] == '0)
      else $error("match index set without a match");

   // a ready receiver never back-pressures the byte stream
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp is ready");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp item offered after reset");

endmodule

bind rom_crc32_signature_match rcsm_checker u_rcsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

FILE: dv/tb_rom_crc32_signature_match.sv
// testbench for the crc-32 signature matcher: directed and random images, scoreboard against a local crc model
`timescale 1ns / 1ps

module tb_rom_crc32_signature_match;

   localparam int unsigned NUM_SIGS      = 8;
   localparam int unsigned CLK_PERIOD    = 10;
   localparam int unsigned RESET_CYCLES  = 5;
   localparam int unsigned RANDOM_ITEMS  = 450;
   localparam int unsigned IDLE_PCT      = 36;
   localparam int unsigned HOLD_AT       = 120;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned QUIET_FROM    = 260;
   localparam int unsigned QUIET_TO      = 340;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // one crc report as the block should give it
   typedef struct packed {
      rcsm_pkg::crc_type     crc;
      logic                  hit;
      rcsm_pkg::sig_idx_type idx;
   } sig_report_type;

   // directed rows: a single byte, or a four-byte tail forged onto a target crc
   typedef enum logic {ROW_BYTE, ROW_FORGE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      rcsm_pkg::byte_type data;
      logic               last;
      logic               pinned;
      sig_report_type     rep;
   } directed_row_type;

   localparam int unsigned DIR_ROWS = 17;

   directed_row_type directed_rows [DIR_ROWS] = '{
      // single-byte images straight after reset, the byte at its extremes
      '{ROW_BYTE,  8'h00, 1'b1, 1'b1, '{32'hD202_EF8D, 1'b0, 3'd0}},
      '{ROW_BYTE,  8'hFF, 1'b1, 1'b1, '{32'hFF00_0000, 1'b0, 3'd0}},
      // the usual check string "123456789"
      '{ROW_BYTE,  8'h31, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h32, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h33, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h34, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h35, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h36, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h37, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h38, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'h39, 1'b1, 1'b1, '{32'hCBF4_3926, 1'b0, 3'd0}},
      // two-byte image, no match
      '{ROW_BYTE,  8'h00, 1'b0, 1'b0, '0},
      '{ROW_BYTE,  8'hFF, 1'b1, 1'b0, '0},
      // images forged onto the first and the last signature
      '{ROW_FORGE, 8'h00, 1'b1, 1'b1, '{rcsm_pkg::SIG_TABLE[0], 1'b1, 3'd0}},
      '{ROW_FORGE, 8'h00, 1'b1, 1'b1, '{rcsm_pkg::SIG_TABLE[7], 1'b1, 3'd7}},
      // prefix byte, then forged onto a middle signature
      '{ROW_BYTE,  8'h80, 1'b0, 1'b0, '0},
      '{ROW_FORGE, 8'h00, 1'b1, 1'b1, '{rcsm_pkg::SIG_TABLE[3], 1'b1, 3'd3}}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rcsm_pkg::BYTE_W-1:0]     req_tdata;    // [7:0] data_byte
   logic                            req_tlast;    // last_byte
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [rcsm_pkg::RSP_DATA_W-1:0] rsp_tdata;    // [31:0] crc_value, [34:32] match_index
   logic                            rsp_tuser;    // matched

   rcsm_pkg::crc_type image_crc;
   sig_report_type    awaited_reports [$];
   int unsigned       items_sent;
   int unsigned       fail_count;
   int unsigned       cycle_count;
   bit                quiet;
   bit                hold_done;

   rom_crc32_signature_match #(
      .NUM_SIGNATURES (NUM_SIGS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always #(CLK_PERIOD/2) clock = ~clock;

   // bit-serial reflected crc step over one byte
   function automatic rcsm_pkg::crc_type fold_image_byte(input rcsm_pkg::crc_type c,
                                                         input rcsm_pkg::byte_type d);
      logic fb;
      for (int i = 0; i < rcsm_pkg::BYTE_W; i++) begin
         fb = c[0] ^ d[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ rcsm_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   // first signature equal to the final crc, index 0 when none
   function automatic sig_report_type grade_signature(input rcsm_pkg::crc_type fin);
      sig_report_type r;
      r = '{fin, 1'b0, '0};
      for (int i = 0; i < rcsm_pkg::SIG_COUNT && i < NUM_SIGS; i++) begin
         if (!r.hit && rcsm_pkg::SIG_TABLE[i] == fin) begin
            r.hit = 1'b1;
            r.idx = i[rcsm_pkg::IDX_W-1:0];
         end
      end
      return r;
   endfunction

   // run 32 crc shifts backwards, used to forge a four-byte tail
   function automatic rcsm_pkg::crc_type unwind_shifts(input rcsm_pkg::crc_type c);
      for (int i = 0; i < rcsm_pkg::CRC_W; i++) begin
         if (c[rcsm_pkg::CRC_W-1]) begin
            c = ((c ^ rcsm_pkg::CRC_POLY) << 1) | 32'h1;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // offer one item with random gaps, then fold it into the model once taken
   task automatic send_byte(input rcsm_pkg::byte_type data, input logic last,
                            input logic pinned, input sig_report_type pinned_rep);
      rcsm_pkg::crc_type fin;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= rcsm_pkg::byte_type'($urandom_range(0, 255));
         req_tlast  <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      items_sent++;
      image_crc = fold_image_byte(image_crc, data);
      if (last) begin
         fin = image_crc ^ rcsm_pkg::CRC_ONES;
         awaited_reports.push_back(pinned ? pinned_rep : grade_signature(fin));
         image_crc = rcsm_pkg::CRC_ONES;
      end
   endtask

   // four bytes that bring the image's final crc onto target, the last one marked
   task automatic send_forged_tail(input rcsm_pkg::crc_type target, input logic pinned,
                                   input sig_report_type pinned_rep);
      rcsm_pkg::crc_type tail;
      tail = image_crc ^ unwind_shifts(target ^ rcsm_pkg::CRC_ONES);
      for (int i = 0; i < 4; i++) begin
         send_byte(tail[8*i +: 8], i == 3, pinned, pinned_rep);
      end
   endtask

   // n random bytes, the last one marked
   task automatic send_random_image(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         send_byte(rcsm_pkg::byte_type'($urandom_range(0, 255)), i == n - 1, 1'b0, '0);
      end
   endtask

   // random prefix, without a closing byte
   task automatic send_prefix(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         send_byte(rcsm_pkg::byte_type'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
   endtask

   // receiver: random back-pressure, one long hold-off
   always begin
      @(negedge clock);
      if (!hold_done && items_sent >= HOLD_AT) begin
         hold_done = 1'b1;
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
      end
      rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // scoreboard on the result channel
   always @(posedge clock) begin
      sig_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected report: crc %h matched %0d index %0d", $time,
                     rsp_tdata[rcsm_pkg::CRC_W-1:0], rsp_tuser,
                     rsp_tdata[rcsm_pkg::RSP_FIELD_W-1:rcsm_pkg::CRC_W]);
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_tdata[rcsm_pkg::CRC_W-1:0] !== want.crc) begin
               $display("%0t: crc mismatch: expected %h actual %h", $time,
                        want.crc, rsp_tdata[rcsm_pkg::CRC_W-1:0]);
               fail_count++;
            end
            if (rsp_tuser !== want.hit) begin
               $display("%0t: matched mismatch: expected %0d actual %0d", $time,
                        want.hit, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[rcsm_pkg::RSP_FIELD_W-1:rcsm_pkg::CRC_W] !== want.idx) begin
               $display("%0t: index mismatch: expected %0d actual %0d", $time,
                        want.idx, rsp_tdata[rcsm_pkg::RSP_FIELD_W-1:rcsm_pkg::CRC_W]);
               fail_count++;
            end
            if (rsp_tdata[rcsm_pkg::RSP_DATA_W-1:rcsm_pkg::RSP_FIELD_W] !== '0) begin
               $display("%0t: padding mismatch: expected 0 actual %h", $time,
                        rsp_tdata[rcsm_pkg::RSP_DATA_W-1:rcsm_pkg::RSP_FIELD_W]);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned stop_at;
      int unsigned choice;
      int unsigned sig;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      image_crc   = rcsm_pkg::CRC_ONES;
      items_sent  = 0;
      fail_count  = 0;
      cycle_count = 0;
      quiet       = 1'b0;
      hold_done   = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_FORGE) begin
            send_forged_tail(directed_rows[r].rep.crc, directed_rows[r].pinned,
                             directed_rows[r].rep);
         end else begin
            send_byte(directed_rows[r].data, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].rep);
         end
      end

      // random images, many forged onto a signature or one bit off one
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         quiet  = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
         choice = $urandom_range(0, 99);
         sig    = $urandom_range(0, rcsm_pkg::SIG_COUNT - 1);
         if (choice < 45) begin
            send_prefix($urandom_range(0, 6));
            send_forged_tail(rcsm_pkg::SIG_TABLE[sig], 1'b0, '0);
         end else if (choice < 53) begin
            // near miss: one bit off a signature
            send_prefix($urandom_range(0, 6));
            send_forged_tail(rcsm_pkg::SIG_TABLE[sig] ^
                             (32'h1 << $urandom_range(0, rcsm_pkg::CRC_W - 1)),
                             1'b0, '0);
         end else if (choice < 68) begin
            send_random_image(1);
         end else if (choice < 72) begin
            send_random_image($urandom_range(24, 48));
         end else begin
            send_random_image($urandom_range(2, 10));
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;

      while (awaited_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/rcsm_pkg.sv
rtl/core/rcsm_match.sv
rtl/core/rom_crc32_signature_match.sv
rtl/core/rcsm_checker.sv
dv/tb_rom_crc32_signature_match.sv
